>>> rtl/crp_pkg.sv
`default_nettype none
// ============================================================================
// crp_pkg: shared types and constants of the cell readback PEC checker.
// Holds the CRC-15 lookup table, the result field widths and the small
// control struct that travels from the frame tracker to the result emitter.
// ============================================================================
package crp_pkg;

    // CRC-15 generator and seed of the packet error code.
    localparam logic [14:0] CRC_POLY = 15'h4599;
    localparam logic [14:0] CRC_SEED = 15'd16;

    // Field widths of the input and result items.
    localparam int BYTE_W     = 8;
    localparam int GROUP_W    = 2;
    localparam int CELL_NUM_W = 4;
    localparam int CODE_W     = 16;

    // Stream payload widths, padded to whole bytes.
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    typedef logic [14:0] crc_table_t [256];

    // Remainder contribution of one byte entering the top of the register.
    function automatic crc_table_t build_crc_table();
        crc_table_t  t;
        logic [14:0] r;
        for (int i = 0; i < 256; i++)
        begin
            r = 15'(i) << 7;
            for (int j = 0; j < 8; j++)
            begin
                if (r[14])
                begin
                    r = (r << 1) ^ CRC_POLY;
                end
                else
                begin
                    r = r << 1;
                end
            end
            t[i] = r;
        end
        return t;
    endfunction

    localparam crc_table_t CRC_TABLE = build_crc_table();

    // One table step of the CRC over a single byte.
    function automatic logic [14:0] crc15_step(input logic [14:0] rem,
                                               input logic [7:0]  data);
        logic [7:0] addr;
        addr = rem[14:7] ^ data;
        return {rem[6:0], 8'h00} ^ CRC_TABLE[addr];
    endfunction

    // Summary of a finished frame handed to the emitter.
    typedef struct packed {
        logic               crc_error;
        logic [GROUP_W-1:0] group;
    } crp_burst_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/crp_frame.sv
`default_nettype none
// ============================================================================
// crp_frame: input register and frame tracker.
// Registers each accepted byte, walks the frame position, runs the CRC over
// the data bytes and, on the last code byte, hands a finished frame onward.
// ============================================================================
module crp_frame
    import crp_pkg::*;
#(
    parameter int CODES_PER_GROUP = 3,
    parameter int GROUP_COUNT     = 4
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [S_TDATA_W-1:0]         s_tdata,   // rx_byte, cell_group
    input  wire logic                         s_tuser,   // frame_start
    output logic                              burst_valid,
    input  wire logic                         burst_ready,
    output crp_burst_ctrl_t                   burst_ctrl,
    output logic [2*CODES_PER_GROUP*8-1:0]    burst_data
);

    localparam int DATA_LEN  = 2 * CODES_PER_GROUP;
    localparam int FRAME_LEN = DATA_LEN + 2;
    localparam int POS_W     = $clog2(FRAME_LEN);
    localparam int IDX_W     = $clog2(DATA_LEN);
    localparam logic [POS_W-1:0] POS_IDLE  = '0;
    localparam logic [POS_W-1:0] POS_PEC_H = POS_W'(DATA_LEN);
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_LEN - 1);

    // Input register.
    logic               in_valid_reg;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic               in_start_reg;
    logic [GROUP_W-1:0] in_group_reg;

    // Frame state.
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [14:0]        crc_reg, crc_next;
    logic [BYTE_W-1:0]  pec_hi_reg;
    logic [GROUP_W-1:0] group_reg;
    logic [BYTE_W-1:0]  data_reg [DATA_LEN];

    logic proc_ready;
    logic proc_fire;
    logic is_final;
    logic data_wr;
    logic [IDX_W-1:0] data_idx;
    logic pec_mismatch;
    logic group_bad;

    // A final byte can only move on once the emitter has room for a frame.
    assign is_final   = in_valid_reg && !in_start_reg && (pos_reg == POS_LAST);
    assign proc_ready = !is_final || burst_ready;
    assign proc_fire  = in_valid_reg && proc_ready;
    assign s_tready   = !in_valid_reg || proc_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg  <= s_tdata[BYTE_W-1:0];
            in_group_reg <= s_tdata[BYTE_W +: GROUP_W];
            in_start_reg <= s_tuser;
        end
    end

    // Next position and remainder for the byte in the input register.
    always_comb
    begin
        pos_next = pos_reg;
        crc_next = crc_reg;
        data_wr  = 1'b0;
        data_idx = pos_reg[IDX_W-1:0];
        if (in_start_reg)
        begin
            pos_next = POS_W'(1);
            crc_next = crc15_step(CRC_SEED, in_byte_reg);
            data_wr  = 1'b1;
            data_idx = '0;
        end
        else if (pos_reg == POS_IDLE)
        begin
            pos_next = pos_reg;
        end
        else if (pos_reg < POS_PEC_H)
        begin
            pos_next = pos_reg + POS_W'(1);
            crc_next = crc15_step(crc_reg, in_byte_reg);
            data_wr  = 1'b1;
        end
        else if (pos_reg == POS_PEC_H)
        begin
            pos_next = pos_reg + POS_W'(1);
        end
        else
        begin
            pos_next = POS_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_IDLE;
            crc_reg    <= CRC_SEED;
            pec_hi_reg <= '0;
            group_reg  <= '0;
        end
        else if (proc_fire)
        begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
            if (in_start_reg)
            begin
                group_reg <= in_group_reg;
            end
            if (!in_start_reg && (pos_reg == POS_PEC_H))
            begin
                pec_hi_reg <= in_byte_reg;
            end
        end
    end

    // Data byte store, written at the current position.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DATA_LEN; i++)
        begin
            if (proc_fire && data_wr && (data_idx == IDX_W'(i)))
            begin
                data_reg[i] <= in_byte_reg;
            end
        end
    end

    // Frame check on the low code byte.
    assign pec_mismatch = {pec_hi_reg, in_byte_reg} != {crc_reg, 1'b0};
    assign group_bad    = {2'b00, group_reg} >= 4'(GROUP_COUNT);

    assign burst_valid          = proc_fire && is_final;
    assign burst_ctrl.crc_error = pec_mismatch || group_bad;
    assign burst_ctrl.group     = group_reg;

    always_comb
    begin
        for (int i = 0; i < DATA_LEN; i++)
        begin
            burst_data[i*8 +: 8] = data_reg[i];
        end
    end

    // A frame is only offered when the emitter can take it.
    a_burst_only_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        burst_valid |-> burst_ready)
        else $error("frame handed over while emitter busy");

    // The position never runs past the last code byte.
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("frame position out of range");

    // A frame start always leaves the tracker after the first data byte.
    a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && in_start_reg) |=> (pos_reg == POS_W'(1)))
        else $error("frame start did not restart the frame");

endmodule
`default_nettype wire

>>> rtl/crp_emit.sv
`default_nettype none
// ============================================================================
// crp_emit: result emitter.
// Holds one finished frame and sends its results, one per cycle unless
// stalled, through the output register: cell codes or a single error result.
// ============================================================================
module crp_emit
    import crp_pkg::*;
#(
    parameter int CODES_PER_GROUP = 3
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          burst_valid,
    output logic                               burst_ready,
    input  wire crp_burst_ctrl_t               burst_ctrl,
    input  wire logic [2*CODES_PER_GROUP*8-1:0] burst_data,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [M_TDATA_W-1:0]               m_tdata,   // cell_number, cell_code
    output logic                               m_tuser,   // crc_error
    output logic                               m_tlast    // last
);

    localparam int K_W = (CODES_PER_GROUP > 1) ? $clog2(CODES_PER_GROUP) : 1;
    localparam logic [K_W-1:0] K_LAST = K_W'(CODES_PER_GROUP - 1);

    // Pending frame.
    logic                               burst_valid_reg;
    crp_burst_ctrl_t                    burst_ctrl_reg;
    logic [2*CODES_PER_GROUP*8-1:0]     burst_data_reg;
    logic [K_W-1:0]                     idx_reg;

    // Output register.
    logic                  m_tvalid_reg;
    logic [CELL_NUM_W-1:0] num_reg;
    logic [CODE_W-1:0]     code_reg;
    logic                  err_reg;
    logic                  last_reg;

    logic                  out_load;
    logic [CELL_NUM_W-1:0] item_num;
    logic [CODE_W-1:0]     item_code;
    logic                  item_last;
    logic [7:0]            num_prod;

    assign burst_ready = !burst_valid_reg;
    assign out_load    = burst_valid_reg && (!m_tvalid_reg || m_tready);

    // Build the next result from the pending frame.
    always_comb
    begin
        num_prod = {6'b000000, burst_ctrl_reg.group} * 8'(CODES_PER_GROUP);
        if (burst_ctrl_reg.crc_error)
        begin
            item_num  = '0;
            item_code = '0;
            item_last = 1'b1;
        end
        else
        begin
            item_num  = num_prod[CELL_NUM_W-1:0] + CELL_NUM_W'(idx_reg);
            item_code = burst_data_reg[idx_reg*CODE_W +: CODE_W];
            item_last = (idx_reg == K_LAST);
        end
    end

    // Frame holding register and result counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_valid_reg <= 1'b0;
            idx_reg         <= '0;
        end
        else if (burst_valid && burst_ready)
        begin
            burst_valid_reg <= 1'b1;
            idx_reg         <= '0;
        end
        else if (out_load)
        begin
            if (item_last)
            begin
                burst_valid_reg <= 1'b0;
                idx_reg         <= '0;
            end
            else
            begin
                idx_reg <= idx_reg + K_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (burst_valid && burst_ready)
        begin
            burst_ctrl_reg <= burst_ctrl;
            burst_data_reg <= burst_data;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            num_reg  <= item_num;
            code_reg <= item_code;
            err_reg  <= burst_ctrl_reg.crc_error;
            last_reg <= item_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - CELL_NUM_W - CODE_W){1'b0}}, code_reg, num_reg};
    assign m_tuser  = err_reg;
    assign m_tlast  = last_reg;

    // An error result carries no code and closes its frame.
    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == '0)))
        else $error("error result not alone in its frame");

    // The result counter stays inside the group of codes.
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        burst_valid_reg |-> (idx_reg <= K_LAST))
        else $error("result counter out of range");

    // Sending the last result frees the frame holding register.
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && item_last) |=> !burst_valid_reg)
        else $error("frame not released after its last result");

endmodule
`default_nettype wire

>>> rtl/cell_readback_pec_checker_unit.sv
`default_nettype none
// ============================================================================
// cell_readback_pec_checker_unit: cell-voltage readback PEC checker.
// Checks the CRC-15 packet error code of a register-group response and
// turns the data bytes into numbered cell codes.
// ============================================================================
// Usage:
//   Input stream: one response byte per request. s_tdata carries the byte in
//   bits 7:0 and the register group in bits 9:8; s_tuser marks the first byte
//   of a response. A response is 2*CODES_PER_GROUP data bytes followed by the
//   two code bytes, high byte first. Bytes outside a response are dropped.
//   Output stream: for a good response, CODES_PER_GROUP results with the cell
//   number in m_tdata[3:0] and the code in m_tdata[19:4], m_tlast on the final
//   one. For a bad code or an out-of-range group, one result with m_tuser set,
//   m_tdata zero and m_tlast set.
//   Throughput: one byte per cycle while s_tready is high; the CRC is one
//   table step per byte. Results leave one per cycle from the output
//   register while m_tready is high. The first result follows the last
//   code byte through the input, frame holding and output registers.
//   Reset clears the input and output valids and returns to waiting for a
//   frame start. When the receiver stalls, results hold in the output
//   register and one finished frame waits behind it; only the last code byte
//   of a following frame is held back, so s_tready drops just then.
// ============================================================================
module cell_readback_pec_checker_unit
    import crp_pkg::*;
#(
    parameter int CODES_PER_GROUP = 3,
    parameter int GROUP_COUNT     = 4
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // rx_byte, cell_group
    input  wire logic                 s_tuser,   // frame_start
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // cell_number, cell_code
    output logic                      m_tuser,   // crc_error
    output logic                      m_tlast    // last
);

    logic                            burst_valid;
    logic                            burst_ready;
    crp_burst_ctrl_t                 burst_ctrl;
    logic [2*CODES_PER_GROUP*8-1:0]  burst_data;

    // Frame tracking and CRC check.
    crp_frame #(
        .CODES_PER_GROUP (CODES_PER_GROUP),
        .GROUP_COUNT     (GROUP_COUNT)
    ) u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .burst_valid (burst_valid),
        .burst_ready (burst_ready),
        .burst_ctrl  (burst_ctrl),
        .burst_data  (burst_data)
    );

    // Result sequencing.
    crp_emit #(
        .CODES_PER_GROUP (CODES_PER_GROUP)
    ) u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .burst_valid (burst_valid),
        .burst_ready (burst_ready),
        .burst_ctrl  (burst_ctrl),
        .burst_data  (burst_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb: stream testbench of the cell readback PEC checker.
// Feeds register-group responses byte by byte: a short table of directed
// frames first (idle bytes, extreme data, a restarted frame, a bad code),
// then random good, corrupted, cut-short and noise traffic. A local model of
// the frame tracker and CRC-15 predicts every cell code and error request,
// and a monitor compares each output request with the oldest prediction.
// ============================================================================
module tb
    import crp_pkg::*;
();

    localparam int CODES_PER_GROUP = 3;
    localparam int GROUP_COUNT     = 4;
    localparam int DATA_BYTES      = 2 * CODES_PER_GROUP;
    localparam logic [14:0] PEC_POLY = 15'h4599;
    localparam logic [14:0] PEC_SEED = 15'd16;
    localparam int RANDOM_ITEMS    = 320;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 12;
    localparam time TIMEOUT_NS     = 5ms;

    // How a directed row picks its byte and how its outcome is checked.
    typedef enum logic [1:0] {FILL_NONE, FILL_PEC_HI, FILL_PEC_LO, FILL_PEC_HI_BAD} pec_fill_t;
    typedef enum logic [1:0] {OUT_PREDICT, OUT_NONE, OUT_ERROR} row_check_t;

    typedef struct {
        logic [7:0] rx;
        logic       start;
        logic [1:0] grp;
        pec_fill_t  fill;
        row_check_t check;
    } stim_row_t;

    typedef struct packed {
        logic [3:0]  cell_num;
        logic [15:0] cell_code;
        logic        pec_err;
        logic        is_last;
    } cell_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // rx_byte, cell_group
    logic                 s_tuser;   // frame_start
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // cell_number, cell_code
    logic                 m_tuser;   // crc_error
    logic                 m_tlast;   // last

    // Local copy of the frame tracker state.
    logic [3:0]  pred_pos;
    logic [14:0] pred_rem;
    logic [7:0]  pred_data [DATA_BYTES];
    logic [7:0]  pred_pec_hi;
    logic [1:0]  pred_grp;

    cell_result_t cell_results_q [$];
    stim_row_t    stim_rows [$];
    int           mismatch_count = 0;
    int           useful_items = 0;
    bit           burst_mode = 1'b0;
    bit           sender_tight = 1'b0;
    bit           hold_off_request = 1'b0;

    cell_readback_pec_checker_unit #(
        .CODES_PER_GROUP (CODES_PER_GROUP),
        .GROUP_COUNT     (GROUP_COUNT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bitwise CRC-15 over one byte, MSB first.
    function automatic logic [14:0] crc15_shift_byte(input logic [14:0] rem,
                                                     input logic [7:0]  data);
        logic [14:0] r;
        r = rem ^ {data, 7'b0};
        for (int i = 0; i < 8; i++)
        begin
            if (r[14])
            begin
                r = (r << 1) ^ PEC_POLY;
            end
            else
            begin
                r = r << 1;
            end
        end
        return r;
    endfunction

    // Packet error code that the current frame should end with.
    function automatic logic [15:0] good_pec();
        return {pred_rem, 1'b0};
    endfunction

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        else if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Data byte with extra weight on the extremes.
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            return 8'h00;
        end
        else if (r == 1)
        begin
            return 8'hFF;
        end
        return 8'($urandom);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // Advance the frame tracker by one accepted byte; queue the cell codes
    // or the error request that the byte completes when keep is set.
    task automatic readback_predict(input logic [7:0] rx, input logic start,
                                    input logic [1:0] grp, input bit keep);
        cell_result_t r;
        logic [15:0]  got_pec;
        if (start)
        begin
            pred_grp     = grp;
            pred_rem     = crc15_shift_byte(PEC_SEED, rx);
            pred_data[0] = rx;
            pred_pos     = 4'd1;
        end
        else if (pred_pos == 0)
        begin
            // Idle: the byte is dropped.
        end
        else if (pred_pos < DATA_BYTES)
        begin
            pred_data[pred_pos] = rx;
            pred_rem            = crc15_shift_byte(pred_rem, rx);
            pred_pos            = pred_pos + 4'd1;
        end
        else if (pred_pos == DATA_BYTES)
        begin
            pred_pec_hi = rx;
            pred_pos    = pred_pos + 4'd1;
        end
        else
        begin
            got_pec  = {pred_pec_hi, rx};
            pred_pos = 4'd0;
            if (got_pec != good_pec() || int'(pred_grp) >= GROUP_COUNT)
            begin
                r = '{cell_num: 4'd0, cell_code: 16'd0, pec_err: 1'b1, is_last: 1'b1};
                if (keep)
                begin
                    cell_results_q.push_back(r);
                end
            end
            else
            begin
                for (int k = 0; k < CODES_PER_GROUP; k++)
                begin
                    r.cell_num  = 4'(int'(pred_grp) * CODES_PER_GROUP + k);
                    r.cell_code = {pred_data[2 * k + 1], pred_data[2 * k]};
                    r.pec_err   = 1'b0;
                    r.is_last   = (k == CODES_PER_GROUP - 1);
                    if (keep)
                    begin
                        cell_results_q.push_back(r);
                    end
                end
            end
        end
    endtask

    // Offer one byte, wait for its request to be taken, then predict.
    task automatic send_byte(input logic [7:0] rx, input logic start,
                             input logic [1:0] grp, input bit keep);
        int gap;
        gap = (burst_mode || sender_tight) ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, grp, rx};
        s_tuser  <= start;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        if (start || pred_pos != 0)
        begin
            useful_items++;
        end
        readback_predict(rx, start, grp, keep);
    endtask

    // Random frame of n_bytes bytes; corrupt flips bits of the code.
    task automatic send_random_frame(input int n_bytes, input logic [15:0] corrupt);
        logic [1:0]  grp;
        logic [15:0] pec;
        grp = 2'($urandom);
        for (int i = 0; i < n_bytes; i++)
        begin
            if (i < DATA_BYTES)
            begin
                send_byte(pick_byte(), i == 0, (i == 0) ? grp : 2'($urandom), 1'b1);
            end
            else
            begin
                pec = good_pec() ^ corrupt;
                send_byte((i == DATA_BYTES) ? pec[15:8] : pec[7:0], 1'b0,
                          2'($urandom), 1'b1);
            end
        end
    endtask

    task automatic add_row(input logic [7:0] rx, input logic start, input logic [1:0] grp,
                           input pec_fill_t fill, input row_check_t check);
        stim_row_t row;
        row = '{rx: rx, start: start, grp: grp, fill: fill, check: check};
        stim_rows.push_back(row);
    endtask

    // Hold the sender until every predicted result has been seen.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (cell_results_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Main stimulus sequence.
    initial
    begin
        logic [7:0]  rx;
        logic [15:0] pec;
        int          kind;
        bit          paused;
        paused   = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        pred_pos    = 4'd0;
        pred_rem    = PEC_SEED;
        pred_pec_hi = 8'd0;
        pred_grp    = 2'd0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Idle bytes after reset are dropped.
        add_row(8'h00, 1'b0, 2'd0, FILL_NONE, OUT_NONE);
        add_row(8'hFF, 1'b0, 2'd3, FILL_NONE, OUT_NONE);
        // Group D, all-ones data, good code.
        add_row(8'hFF, 1'b1, 2'd3, FILL_NONE, OUT_PREDICT);
        for (int i = 1; i < DATA_BYTES; i++)
        begin
            add_row(8'hFF, 1'b0, 2'd0, FILL_NONE, OUT_PREDICT);
        end
        add_row(8'h00, 1'b0, 2'd0, FILL_PEC_HI, OUT_PREDICT);
        add_row(8'h00, 1'b0, 2'd0, FILL_PEC_LO, OUT_PREDICT);
        // Bytes after the code are dropped.
        add_row(8'hAA, 1'b0, 2'd1, FILL_NONE, OUT_NONE);
        add_row(8'h55, 1'b0, 2'd2, FILL_NONE, OUT_NONE);
        // A frame cut short by a new frame start.
        add_row(8'h12, 1'b1, 2'd0, FILL_NONE, OUT_PREDICT);
        add_row(8'h34, 1'b0, 2'd0, FILL_NONE, OUT_PREDICT);
        // Group B, all-zero data, inverted high code byte: one error result.
        add_row(8'h00, 1'b1, 2'd1, FILL_NONE, OUT_PREDICT);
        for (int i = 1; i < DATA_BYTES; i++)
        begin
            add_row(8'h00, 1'b0, 2'd0, FILL_NONE, OUT_PREDICT);
        end
        add_row(8'h00, 1'b0, 2'd0, FILL_PEC_HI_BAD, OUT_PREDICT);
        add_row(8'h00, 1'b0, 2'd0, FILL_PEC_LO, OUT_ERROR);

        foreach (stim_rows[i])
        begin
            pec = good_pec();
            case (stim_rows[i].fill)
                FILL_PEC_HI:     rx = pec[15:8];
                FILL_PEC_LO:     rx = pec[7:0];
                FILL_PEC_HI_BAD: rx = pec[15:8] ^ 8'hFF;
                default:         rx = stim_rows[i].rx;
            endcase
            send_byte(rx, stim_rows[i].start, stim_rows[i].grp,
                      stim_rows[i].check == OUT_PREDICT);
            if (stim_rows[i].check == OUT_ERROR)
            begin
                cell_results_q.push_back('{cell_num: 4'd0, cell_code: 16'd0,
                                           pec_err: 1'b1, is_last: 1'b1});
            end
        end
        drain_results();

        // Back-to-back good frames while the receiver holds off.
        useful_items     = 0;
        hold_off_request = 1'b1;
        burst_mode       = 1'b1;
        for (int f = 0; f < 6; f++)
        begin
            send_random_frame(DATA_BYTES + 2, 16'd0);
        end
        burst_mode = 1'b0;

        // Random traffic: mostly well-formed frames.
        while (useful_items < RANDOM_ITEMS)
        begin
            sender_tight = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 68)
            begin
                send_random_frame(DATA_BYTES + 2, 16'd0);
            end
            else if (kind < 82)
            begin
                pec = 16'd1 << $urandom_range(0, 15);
                if ($urandom_range(0, 3) == 0)
                begin
                    pec = 16'($urandom) | 16'd1;
                end
                send_random_frame(DATA_BYTES + 2, pec);
            end
            else if (kind < 92)
            begin
                send_random_frame($urandom_range(1, DATA_BYTES + 1), 16'd0);
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                begin
                    send_byte(pick_byte(), 1'b0, 2'($urandom), 1'b1);
                end
            end
            if (!paused && useful_items >= RANDOM_ITEMS / 2)
            begin
                paused = 1'b1;
                drain_results();
            end
        end
        sender_tight = 1'b0;

        drain_results();
        if (mismatch_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Compare each accepted result request with the oldest prediction.
    always @(posedge clk)
    begin
        cell_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (cell_results_q.size() == 0)
            begin
                report_mismatch("unexpected result", 32'(m_tdata), 32'd0);
            end
            else
            begin
                want = cell_results_q.pop_front();
                if (m_tdata[3:0] !== want.cell_num)
                begin
                    report_mismatch("cell_number", 32'(m_tdata[3:0]), 32'(want.cell_num));
                end
                if (m_tdata[19:4] !== want.cell_code)
                begin
                    report_mismatch("cell_code", 32'(m_tdata[19:4]), 32'(want.cell_code));
                end
                if (m_tuser !== want.pec_err)
                begin
                    report_mismatch("crc_error", 32'(m_tuser), 32'(want.pec_err));
                end
                if (m_tlast !== want.is_last)
                begin
                    report_mismatch("last", 32'(m_tlast), 32'(want.is_last));
                end
            end
        end
    end

    // Watchdog.
    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> files.f
rtl/crp_pkg.sv
rtl/crp_frame.sv
rtl/crp_emit.sv
rtl/cell_readback_pec_checker_unit.sv
tb/tb.sv
